### rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// Bounded circular deque: shared package
// Types, action codes and sizes used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package bcd_pkg;

  // Ring depth; must stay a power of two so that index wrap is a truncation.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int CAP_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Action codes carried by an input transaction.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_REAR   = 3'd3;
  localparam logic [2:0] ACT_PEEK       = 3'd4;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         occupancy;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // apply the accepted action to pointers and ring
    logic rd;     // read front and rear entries from the ring
    logic load;   // capture the result into the output register
  } dp_cmd_t;

endpackage

### rtl/bcd_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded circular deque: controller
// Sequences each transaction through execute, ring read and result load, and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module bcd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output bcd_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // The output register may be refilled when empty or being taken this edge.
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/bcd_datapath.sv
// ----------------------------------------------------------------------------
// Bounded circular deque: datapath
// Ring storage, front index and entry count, capacity register and the
// output register.
// ----------------------------------------------------------------------------
module bcd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  bcd_pkg::dp_cmd_t            cmd,
  input  bcd_pkg::in_item_t           in_data,
  output bcd_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [bcd_pkg::CAP_W-1:0]   cfg_wdata,
  output logic [bcd_pkg::CAP_W-1:0]   capacity
);

  logic [bcd_pkg::DATA_W-1:0] ring [bcd_pkg::DEPTH];

  logic [bcd_pkg::IDX_W-1:0]  front_index;
  logic [bcd_pkg::IDX_W-1:0]  front_index_next;
  logic [bcd_pkg::CNT_W-1:0]  entry_count;
  logic [bcd_pkg::CNT_W-1:0]  entry_count_next;
  logic [bcd_pkg::CNT_W-1:0]  eff_cap;
  logic                       ok;
  logic                       ok_next;
  logic                       wr_en;
  logic [bcd_pkg::IDX_W-1:0]  wr_addr;
  logic [bcd_pkg::IDX_W-1:0]  rear_index;
  logic [bcd_pkg::DATA_W-1:0] front_q;
  logic [bcd_pkg::DATA_W-1:0] rear_q;
  logic                       can_push;
  logic                       can_pop;
  logic                       is_empty;

  // Capacity above the ring depth saturates at the depth.
  assign eff_cap = (capacity > bcd_pkg::CAP_W'(bcd_pkg::DEPTH))
                   ? bcd_pkg::CNT_W'(bcd_pkg::DEPTH) : bcd_pkg::CNT_W'(capacity);

  assign can_push = (entry_count < eff_cap);
  assign can_pop  = (entry_count != '0);
  assign is_empty = (entry_count == '0);

  // Rear entry sits at front + count - 1, wrapped by truncation.
  assign rear_index = front_index + bcd_pkg::IDX_W'(entry_count - bcd_pkg::CNT_W'(1));

  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    ok_next          = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = front_index;
    unique case (in_data.action)
      bcd_pkg::ACT_PUSH_FRONT: begin
        if (can_push) begin
          front_index_next = front_index - bcd_pkg::IDX_W'(1);
          wr_addr          = front_index - bcd_pkg::IDX_W'(1);
          wr_en            = 1'b1;
          entry_count_next = entry_count + bcd_pkg::CNT_W'(1);
          ok_next          = 1'b1;
        end
      end
      bcd_pkg::ACT_PUSH_REAR: begin
        if (can_push) begin
          wr_addr          = front_index + bcd_pkg::IDX_W'(entry_count);
          wr_en            = 1'b1;
          entry_count_next = entry_count + bcd_pkg::CNT_W'(1);
          ok_next          = 1'b1;
        end
      end
      bcd_pkg::ACT_POP_FRONT: begin
        if (can_pop) begin
          front_index_next = front_index + bcd_pkg::IDX_W'(1);
          entry_count_next = entry_count - bcd_pkg::CNT_W'(1);
          ok_next          = 1'b1;
        end
      end
      bcd_pkg::ACT_POP_REAR: begin
        if (can_pop) begin
          entry_count_next = entry_count - bcd_pkg::CNT_W'(1);
          ok_next          = 1'b1;
        end
      end
      bcd_pkg::ACT_PEEK: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
      capacity    <= bcd_pkg::CAP_RESET;
    end else begin
      if (cmd.exec) begin
        front_index <= front_index_next;
        entry_count <= entry_count_next;
      end
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok <= ok_next;
    end
  end

  // Ring: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring[wr_addr] <= in_data.value;
    end
    if (cmd.rd) begin
      front_q <= ring[front_index];
      rear_q  <= ring[rear_index];
    end
  end

  // An empty deque reports all ones for both ends.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.ok          <= ok;
      out_data.front_value <= is_empty ? '1 : front_q;
      out_data.rear_value  <= is_empty ? '1 : rear_q;
      out_data.is_empty    <= is_empty;
      out_data.is_full     <= (entry_count >= eff_cap);
      out_data.occupancy   <= entry_count;
    end
  end

endmodule

### rtl/bounded_circular_deque.sv
// An accepted transaction passes through ring read, then result load into the output register.
// The input stalls until the result load, so the next transaction is taken only once the last is loaded.
// The result register lets the next transaction start while a result waits.
// Reset (synchronous, rst high) empties the deque and sets capacity to 16;
// ring contents are not cleared, and an unwritten entry never reaches the output.
// ----------------------------------------------------------------------------
// Bounded circular deque: top level
// Double-ended queue on a ring buffer with an APB-style capacity register.
// ----------------------------------------------------------------------------
module bounded_circular_deque (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bcd_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  bcd_pkg::dp_cmd_t            cmd;
  logic                        cfg_we;
  logic [bcd_pkg::CAP_W-1:0]   capacity;

  assign pready = 1'b1;
  // The capacity register is the only one; it answers at every address with paddr[2] low (0 to 3).
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(capacity);

  bcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bcd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[bcd_pkg::CAP_W-1:0]),
    .capacity  (capacity)
  );

endmodule

### tb/bcd_deque_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded circular deque: result checker
// Watches the input, output and capacity ports, keeps its own copy of the ring
// and predicts each result in order. Mismatches are counted for the top level.
// ----------------------------------------------------------------------------
module bcd_deque_checker
  import bcd_pkg::*;
#(
  parameter logic [2:0] CAP_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          waiting
);

  logic [DATA_W-1:0] shadow_slots [DEPTH];
  logic [IDX_W-1:0]  shadow_head;
  logic [CNT_W-1:0]  shadow_count;
  logic [CAP_W-1:0]  shadow_cap;
  out_item_t         expected_results [$];

  // Applies one action to the shadow deque and returns the state it leaves.
  function automatic out_item_t deque_apply(in_item_t item);
    out_item_t        res;
    logic [CAP_W-1:0] limit;
    logic [IDX_W-1:0] slot;
    limit = (shadow_cap > DEPTH) ? CAP_W'(DEPTH) : shadow_cap;
    res = '0;
    case (item.action)
      ACT_PUSH_FRONT: begin
        if (shadow_count < limit) begin
          shadow_head = shadow_head - 1'b1;
          shadow_slots[shadow_head] = item.value;
          shadow_count = shadow_count + 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_PUSH_REAR: begin
        if (shadow_count < limit) begin
          slot = shadow_head + shadow_count[IDX_W-1:0];
          shadow_slots[slot] = item.value;
          shadow_count = shadow_count + 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_count != 0) begin
          shadow_head = shadow_head + 1'b1;
          shadow_count = shadow_count - 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_POP_REAR: begin
        if (shadow_count != 0) begin
          shadow_count = shadow_count - 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_PEEK: res.ok = 1'b1;
      default: res.ok = 1'b0;
    endcase
    if (shadow_count != 0) begin
      slot = shadow_head + shadow_count[IDX_W-1:0] - 1'b1;
      res.front_value = shadow_slots[shadow_head];
      res.rear_value = shadow_slots[slot];
    end else begin
      res.front_value = '1;
      res.rear_value = '1;
    end
    res.is_empty = (shadow_count == 0);
    res.is_full = (shadow_count >= limit);
    res.occupancy = shadow_count;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      shadow_head = '0;
      shadow_count = '0;
      shadow_cap = CAP_RESET;
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: result %h arrived with nothing expected", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_data.ok));
          check_field("front_value", want.front_value, out_data.front_value);
          check_field("rear_value", want.rear_value, out_data.rear_value);
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(out_data.is_full));
          check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(deque_apply(in_data));
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        shadow_cap = pwdata[CAP_W-1:0];
    end
    waiting = expected_results.size();
  end

endmodule

### tb/tb_bounded_circular_deque.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded circular deque: testbench top
// Sends directed and random deque actions under several capacity settings,
// with random gaps and stalls on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_bounded_circular_deque;
  import bcd_pkg::*;

  localparam logic [2:0] CAPACITY_ADDR = 3'd0;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int HOLD_CYCLES = 160;
  localparam int PHASE_ITEMS = 95;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          waiting;
  int          hold_requests = 0;
  int          holds_done = 0;
  bit          sender_calm = 1'b0;
  bit          sender_burst = 1'b0;

  bounded_circular_deque uut (.*);

  bcd_deque_checker #(.CAP_ADDR(CAPACITY_ADDR)) deque_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    if (r < 10) return ACT_PEEK;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    return $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
  endfunction

  // Offers one transaction and returns at the clock edge that accepts it.
  task automatic offer(input logic [2:0] act, input logic [31:0] val);
    in_item_t item;
    int       gap;
    item.action = act;
    item.value = val;
    gap = (sender_burst || sender_calm || $urandom_range(0, 2) != 0) ? 0 : stall_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= cap;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Receiver: random stalls with calm stretches, plus the long hold-offs that
  // the stimulus asks for so that the block fills and stalls its input.
  initial begin
    int  hold_left;
    int  gap_left;
    int  calm_left;
    bit  calm;
    hold_left = 0;
    gap_left = 0;
    calm_left = 0;
    calm = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (calm_left == 0) begin
        calm_left = 200;
        calm = ($urandom_range(0, 3) == 0);
      end
      calm_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap_left = stall_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int phase_caps [9];
    int push_pct;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    phase_caps = '{31, 1, 16, 5, 0, 17, 8, 16, 3};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty deque at the reset capacity, then the data extremes at both ends.
    offer(ACT_PEEK, 32'h1234_5678);
    offer(ACT_POP_FRONT, 32'h0);
    offer(ACT_POP_REAR, 32'h0);
    offer(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    offer(ACT_PUSH_REAR, 32'h8000_0000);
    offer(ACT_PUSH_FRONT, 32'h0000_0000);
    offer(ACT_PUSH_REAR, 32'hFFFF_FFFF);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      offer(3'(a), 32'hDEAD_BEEF);
    offer(ACT_PEEK, 32'h0);
    offer(ACT_POP_REAR, 32'h0);
    offer(ACT_POP_FRONT, 32'h0);
    offer(ACT_POP_FRONT, 32'h0);
    offer(ACT_POP_REAR, 32'h0);
    offer(ACT_POP_FRONT, 32'h0);

    // A small capacity that fills, then capacity zero with entries still held.
    settle();
    write_capacity(32'd2);
    offer(ACT_PUSH_REAR, 32'hA5A5_A5A5);
    offer(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
    offer(ACT_PUSH_REAR, 32'h0000_0001);
    settle();
    write_capacity(32'd0);
    offer(ACT_PUSH_FRONT, 32'h0000_0002);
    offer(ACT_POP_REAR, 32'h0);
    offer(ACT_POP_FRONT, 32'h0);
    offer(ACT_PUSH_REAR, 32'h0000_0003);

    // Random phases; the push share swings so the deque fills and drains.
    for (int p = 0; p < 9; p++) begin
      settle();
      write_capacity(p == 6 ? $urandom_range(2, 15) : phase_caps[p]);
      sender_calm = (p % 3 == 1);
      sender_burst = (p == 2 || p == 6);
      if (sender_burst) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_pct = ((i / 24) % 2 == 0) ? 72 : 30;
        offer(pick_action(push_pct), pick_value());
      end
      sender_burst = 1'b0;
    end

    settle();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### bounded_circular_deque.f
rtl/bcd_pkg.sv
rtl/bcd_ctrl.sv
rtl/bcd_datapath.sv
rtl/bounded_circular_deque.sv
tb/bcd_deque_checker.sv
tb/tb_bounded_circular_deque.sv
